FILE: hdl/mahs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mahs_pkg
// Shared types and constants of the multi-axis homing sequencer.
// ----------------------------------------------------------------------------
package mahs_pkg;

  // configuration register widths and reset values
  localparam int MAX_STEPS_W   = 24;
  localparam int TIMEOUT_W     = 32;
  localparam int RF_W          = 8;
  localparam int CFG_ADDR_W    = 3;
  localparam int CFG_DATA_W    = 32;
  localparam int OP_W          = 3;

  localparam logic [MAX_STEPS_W-1:0] MAX_STEPS_RST  = 24'd16000;
  localparam logic [TIMEOUT_W-1:0]   TIMEOUT_RST    = 32'd30000;
  localparam logic [RF_W-1:0]        RF_LIMIT_RST   = 8'd5;
  localparam logic [RF_W-1:0]        RF_COUNT_MAX   = 8'd255;

  // configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_MAX_STEPS       = 3'd0,
    CFG_TIMEOUT_MS      = 3'd1,
    CFG_READ_FAIL_LIMIT = 3'd2,
    CFG_APPROACH_EN     = 3'd3,
    CFG_OVERTRAVEL_EN   = 3'd4
  } cfg_reg_t;

  // event kinds on the input stream
  typedef enum logic [OP_W-1:0] {
    OP_TICK        = 3'd0,
    OP_HOME        = 3'd1,
    OP_ABORT       = 3'd2,
    OP_FAULT_RESET = 3'd3,
    OP_OVERTRAVEL  = 3'd4,
    OP_POWER_UP    = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    STAGE_IDLE     = 2'd0,
    STAGE_APPROACH = 2'd1,
    STAGE_CASCADE  = 2'd2
  } stage_t;

  typedef enum logic [2:0] {
    CMD_NONE      = 3'd0,
    CMD_START     = 3'd1,
    CMD_STOP      = 3'd2,
    CMD_MOVE_ZERO = 3'd3,
    CMD_APPROACH  = 3'd4,
    CMD_ESTOP     = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    EVT_NONE          = 3'd0,
    EVT_READ_FAIL     = 3'd1,
    EVT_AXIS_FAULT    = 3'd2,
    EVT_OT_TRIP       = 3'd3,
    EVT_DONE          = 3'd4,
    EVT_CASCADE_START = 3'd5,
    EVT_ABORT         = 3'd6
  } evt_t;

  typedef enum logic [1:0] {
    FK_NONE       = 2'd0,
    FK_HOMING     = 2'd1,
    FK_OVERTRAVEL = 2'd2
  } fault_kind_t;

  // control of the per-axis pulse counters
  typedef struct packed {
    logic clear;
    logic count;
  } lane_ctrl_t;

endpackage

FILE: hdl/mahs_pulse_lanes.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mahs_pulse_lanes
// Per-axis saturating pulse counters with over-limit compare.
// ----------------------------------------------------------------------------
module mahs_pulse_lanes #(
  parameter int NUM_AXES   = 9,
  parameter int COUNT_BITS = 24
) (
  input  logic                           clk,
  input  logic                           rst,
  input  mahs_pkg::lane_ctrl_t           ctrl,
  input  logic [NUM_AXES-1:0]            steps,
  input  logic [mahs_pkg::MAX_STEPS_W-1:0] max_steps,
  output logic [NUM_AXES-1:0]            over_mask
);
  import mahs_pkg::*;

  localparam int CMP_W = (COUNT_BITS > MAX_STEPS_W) ? COUNT_BITS : MAX_STEPS_W;

  logic [COUNT_BITS-1:0] count     [NUM_AXES];
  logic [COUNT_BITS-1:0] count_inc [NUM_AXES];

  for (genvar i = 0; i < NUM_AXES; i++) begin : g_lane
    // add this tick's pulse, holding at full scale
    assign count_inc[i] = (steps[i] && (count[i] != {COUNT_BITS{1'b1}})) ?
                          count[i] + 1'b1 : count[i];

    // judged on the count including this tick
    assign over_mask[i] = CMP_W'(count_inc[i]) > CMP_W'(max_steps);

    always_ff @(posedge clk) begin
      if (rst || ctrl.clear) begin
        count[i] <= '0;
      end else if (ctrl.count) begin
        count[i] <= count_inc[i];
      end
    end
  end

endmodule

FILE: hdl/multi_axis_homing_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_axis_homing_sequencer
// Homing sequencer for a row of stepper axes: approach, pulse cascade,
// per-axis over-limit, timeout, read-failure and over-travel faults.
// ----------------------------------------------------------------------------
//  channel   | direction | contents
//  ----------+-----------+------------------------------------------------
//  s_axis    | in        | one event beat: op in tuser, sensor data in tdata
//  m_axis    | out       | one result beat per event
//  cfg       | in        | register write, index + data, no read-back
//
// Beats pass through the input register, then the result register; one
// beat is taken every cycle while the result is not stalled. Each event is
// decoded combinationally between the two registers; the per-axis counters
// and the 32-bit elapsed-time compare set that path. Reset is synchronous
// and clears all state. A stalled result holds and backs up the input
// register, and the input side stalls only while both are full.
// ----------------------------------------------------------------------------
module multi_axis_homing_sequencer #(
  parameter int NUM_AXES   = 9,
  parameter int COUNT_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst,
  // op
  input  logic [mahs_pkg::OP_W-1:0]         s_tuser,
  // time_ms, io_valid, home_sensors, step_mask, move_done,
  // all_within_approach, overtravel_left, overtravel_right, manual_mode
  input  logic [((38+2*NUM_AXES+7)/8)*8-1:0] s_tdata,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // stage, run_mask, command, fault_active, fault_axes, fault_kind,
  // positions_valid, request_accepted, event_code
  output logic [((13+2*NUM_AXES+7)/8)*8-1:0] m_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  input  logic                              cfg_we,
  input  logic [mahs_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [mahs_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import mahs_pkg::*;

  localparam int OUT_W = ((13 + 2*NUM_AXES + 7) / 8) * 8;
  localparam int OFS_IO    = 32;
  localparam int OFS_SENS  = 33;
  localparam int OFS_STEP  = 33 + NUM_AXES;
  localparam int OFS_FLAGS = 33 + 2*NUM_AXES;
  localparam logic [NUM_AXES-1:0] ALL_AXES = {NUM_AXES{1'b1}};
  localparam logic [NUM_AXES-1:0] END_LEFT  = NUM_AXES'(1);
  localparam logic [NUM_AXES-1:0] END_RIGHT = NUM_AXES'(1) << (NUM_AXES - 1);

  // configuration registers
  logic [MAX_STEPS_W-1:0] max_steps;
  logic [TIMEOUT_W-1:0]   timeout_ms;
  logic [RF_W-1:0]        read_fail_limit;
  logic                   approach_enabled;
  logic                   ot_alarm_en;

  // input register
  logic                in_valid;
  op_t                 in_op;
  logic [31:0]         in_time;
  logic                in_io;
  logic [NUM_AXES-1:0] in_sens;
  logic [NUM_AXES-1:0] in_step;
  logic                in_move_done;
  logic                in_within;
  logic                in_ot_left;
  logic                in_ot_right;
  logic                in_manual;

  // sequencer state
  stage_t              stage_reg,        stage_next;
  logic                pos_valid_reg,    pos_valid_next;
  logic                fault_latched,    fault_latched_next;
  logic [NUM_AXES-1:0] fault_axes_reg,   fault_axes_next;
  fault_kind_t         fault_kind_reg,   fault_kind_next;
  logic [RF_W-1:0]     read_fail_count,  read_fail_count_next;
  logic [31:0]         cascade_start_ms, cascade_start_ms_next;
  logic                start_pos_valid,  start_pos_valid_next;

  // result register
  stage_t              out_stage;
  logic [NUM_AXES-1:0] out_run,  run_next;
  cmd_t                out_cmd,  cmd_next;
  logic                out_fault;
  logic [NUM_AXES-1:0] out_faxes;
  fault_kind_t         out_fkind;
  logic                out_posv;
  logic                out_acc,  acc_next;
  evt_t                out_evt,  evt_next;

  // decode
  logic                advance;
  logic                cascade_tick;
  logic                home_ok;
  logic                begin_cascade;
  logic                to_approach;
  logic                home_zero;
  logic                abort_cascade;
  logic                fault_reset;
  logic                raise_fault;
  logic [NUM_AXES-1:0] raise_axes;
  fault_kind_t         raise_kind;
  logic                done;
  logic                timed_out;
  logic                read_fail;
  logic [RF_W-1:0]     rf_inc;
  logic [NUM_AXES-1:0] not_on;
  logic [NUM_AXES-1:0] over_mask;
  logic [NUM_AXES-1:0] ot_mask;
  logic [NUM_AXES-1:0] ot_read;
  logic                ot_take;
  lane_ctrl_t          lane_ctrl;

  // handshake: the result register frees a slot, the input register follows
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  // input beat capture
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op        <= op_t'(s_tuser);
      in_time      <= s_tdata[31:0];
      in_io        <= s_tdata[OFS_IO];
      in_sens      <= s_tdata[OFS_SENS +: NUM_AXES];
      in_step      <= s_tdata[OFS_STEP +: NUM_AXES];
      in_move_done <= s_tdata[OFS_FLAGS];
      in_within    <= s_tdata[OFS_FLAGS + 1];
      in_ot_left   <= s_tdata[OFS_FLAGS + 2];
      in_ot_right  <= s_tdata[OFS_FLAGS + 3];
      in_manual    <= s_tdata[OFS_FLAGS + 4];
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      max_steps        <= MAX_STEPS_RST;
      timeout_ms       <= TIMEOUT_RST;
      read_fail_limit  <= RF_LIMIT_RST;
      approach_enabled <= 1'b1;
      ot_alarm_en      <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        CFG_MAX_STEPS:       max_steps        <= cfg_data[MAX_STEPS_W-1:0];
        CFG_TIMEOUT_MS:      timeout_ms       <= cfg_data[TIMEOUT_W-1:0];
        CFG_READ_FAIL_LIMIT: read_fail_limit  <= cfg_data[RF_W-1:0];
        CFG_APPROACH_EN:     approach_enabled <= cfg_data[0];
        CFG_OVERTRAVEL_EN:   ot_alarm_en      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // per-axis pulse counters
  assign lane_ctrl.clear = advance && begin_cascade;
  assign lane_ctrl.count = advance && cascade_tick;

  mahs_pulse_lanes #(
    .NUM_AXES   (NUM_AXES),
    .COUNT_BITS (COUNT_BITS)
  ) u_lanes (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (lane_ctrl),
    .steps     (in_step),
    .max_steps (max_steps),
    .over_mask (over_mask)
  );

  // event decode shared by next state and outputs
  always_comb begin
    not_on       = ~in_sens;
    rf_inc       = (read_fail_count == RF_COUNT_MAX) ? read_fail_count
                                                     : read_fail_count + 1'b1;
    timed_out    = (in_time - cascade_start_ms) > timeout_ms;
    home_ok      = !fault_latched && (stage_reg == STAGE_IDLE);
    cascade_tick = (in_op == OP_TICK) && (stage_reg == STAGE_CASCADE);
    read_fail    = cascade_tick && !in_io;
    fault_reset  = (in_op == OP_FAULT_RESET) && fault_latched;
    abort_cascade = (in_op == OP_ABORT) && (stage_reg == STAGE_CASCADE);

    ot_read = '0;
    if (in_io) begin
      ot_read = (in_ot_left ? END_LEFT : '0) | (in_ot_right ? END_RIGHT : '0);
    end
    ot_mask = (ot_read == '0) ? (END_LEFT | END_RIGHT) : ot_read;
    ot_take = (in_op == OP_OVERTRAVEL) && ot_alarm_en && !fault_latched &&
              (stage_reg != STAGE_CASCADE) && !in_manual;

    home_zero   = (in_op == OP_HOME) && home_ok && pos_valid_reg && !approach_enabled;
    to_approach = (in_op == OP_HOME) && home_ok && pos_valid_reg && approach_enabled &&
                  !in_within;

    begin_cascade =
      ((in_op == OP_TICK) && (stage_reg == STAGE_APPROACH) && in_move_done) ||
      ((in_op == OP_HOME) && home_ok &&
       (!pos_valid_reg || (approach_enabled && in_within))) ||
      fault_reset ||
      ((in_op == OP_POWER_UP) && in_io && !in_manual && (in_sens != ALL_AXES));

    raise_fault = 1'b0;
    raise_axes  = '0;
    raise_kind  = FK_HOMING;
    done        = 1'b0;
    if (read_fail) begin
      if (rf_inc >= read_fail_limit) begin
        raise_fault = 1'b1;
        raise_axes  = ALL_AXES;
      end
    end else if (cascade_tick) begin
      if ((not_on & over_mask) != '0) begin
        raise_fault = 1'b1;
        raise_axes  = not_on & over_mask;
      end else if (timed_out) begin
        raise_fault = 1'b1;
        raise_axes  = not_on;
      end else if (not_on == '0) begin
        done = 1'b1;
      end
    end else if (ot_take) begin
      raise_fault = 1'b1;
      raise_axes  = ot_mask;
      raise_kind  = FK_OVERTRAVEL;
    end else if ((in_op == OP_POWER_UP) && !in_io) begin
      raise_fault = 1'b1;
      raise_axes  = ALL_AXES;
    end
  end

  // next state
  always_comb begin
    stage_next            = stage_reg;
    pos_valid_next        = pos_valid_reg;
    fault_latched_next    = fault_latched;
    fault_axes_next       = fault_axes_reg;
    fault_kind_next       = fault_kind_reg;
    read_fail_count_next  = read_fail_count;
    cascade_start_ms_next = cascade_start_ms;
    start_pos_valid_next  = start_pos_valid;

    if (fault_reset) begin
      fault_latched_next = 1'b0;
      fault_axes_next    = '0;
      fault_kind_next    = FK_NONE;
    end
    if (cascade_tick) begin
      read_fail_count_next = in_io ? '0 : rf_inc;
    end
    if (begin_cascade) begin
      stage_next            = STAGE_CASCADE;
      read_fail_count_next  = '0;
      cascade_start_ms_next = in_time;
      start_pos_valid_next  = pos_valid_reg;
    end
    if (to_approach) begin
      stage_next = STAGE_APPROACH;
    end
    if (in_op == OP_ABORT) begin
      stage_next = STAGE_IDLE;
    end
    if (abort_cascade && !start_pos_valid) begin
      pos_valid_next = 1'b0;
    end
    if ((in_op == OP_POWER_UP) && in_io && !in_manual && (in_sens == ALL_AXES)) begin
      pos_valid_next = 1'b1;
    end
    if (done) begin
      stage_next     = STAGE_IDLE;
      pos_valid_next = 1'b1;
    end
    if (raise_fault) begin
      stage_next         = STAGE_IDLE;
      pos_valid_next     = 1'b0;
      fault_latched_next = 1'b1;
      fault_axes_next    = raise_axes;
      fault_kind_next    = raise_kind;
    end
  end

  // result fields of this beat
  always_comb begin
    cmd_next = CMD_NONE;
    evt_next = EVT_NONE;
    run_next = '0;
    acc_next = (in_op == OP_HOME) && home_ok;

    if (begin_cascade) begin
      cmd_next = CMD_START;
      evt_next = EVT_CASCADE_START;
    end else if (raise_fault) begin
      cmd_next = (raise_kind == FK_OVERTRAVEL) ? CMD_ESTOP : CMD_STOP;
      evt_next = (raise_kind == FK_OVERTRAVEL) ? EVT_OT_TRIP : EVT_AXIS_FAULT;
    end else if (read_fail) begin
      cmd_next = CMD_STOP;
      evt_next = (rf_inc == RF_W'(1)) ? EVT_READ_FAIL : EVT_NONE;
    end else if (done) begin
      cmd_next = CMD_STOP;
      evt_next = EVT_DONE;
    end else if (cascade_tick) begin
      run_next = not_on;
    end else if (home_zero) begin
      cmd_next = CMD_MOVE_ZERO;
    end else if (to_approach) begin
      cmd_next = CMD_APPROACH;
    end else if (in_op == OP_ABORT) begin
      cmd_next = abort_cascade ? CMD_STOP : CMD_NONE;
      evt_next = EVT_ABORT;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_reg        <= STAGE_IDLE;
      pos_valid_reg    <= 1'b0;
      fault_latched    <= 1'b0;
      fault_axes_reg   <= '0;
      fault_kind_reg   <= FK_NONE;
      read_fail_count  <= '0;
      cascade_start_ms <= '0;
      start_pos_valid  <= 1'b0;
    end else if (advance) begin
      stage_reg        <= stage_next;
      pos_valid_reg    <= pos_valid_next;
      fault_latched    <= fault_latched_next;
      fault_axes_reg   <= fault_axes_next;
      fault_kind_reg   <= fault_kind_next;
      read_fail_count  <= read_fail_count_next;
      cascade_start_ms <= cascade_start_ms_next;
      start_pos_valid  <= start_pos_valid_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_stage <= stage_next;
      out_run   <= run_next;
      out_cmd   <= cmd_next;
      out_fault <= fault_latched_next;
      out_faxes <= fault_axes_next;
      out_fkind <= fault_kind_next;
      out_posv  <= pos_valid_next;
      out_acc   <= acc_next;
      out_evt   <= evt_next;
    end
  end

  assign m_tdata = OUT_W'({out_evt, out_acc, out_posv, out_fkind, out_faxes, out_fault,
                           out_cmd, out_run, out_stage});

  // checks
  a_fault_kind_set: assert property (@(posedge clk) disable iff (rst)
    fault_latched |-> (fault_kind_reg != FK_NONE))
    else $error("latched fault without a kind");

  a_fault_clear: assert property (@(posedge clk) disable iff (rst)
    !fault_latched |-> (fault_kind_reg == FK_NONE) && (fault_axes_reg == '0))
    else $error("fault fields left over after clear");

  a_run_in_cascade: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (out_run != '0) |-> (out_stage == STAGE_CASCADE) && (out_cmd == CMD_NONE))
    else $error("run mask outside a running cascade");

  a_accept_cmd: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_acc |->
      (out_cmd == CMD_START) || (out_cmd == CMD_MOVE_ZERO) || (out_cmd == CMD_APPROACH))
    else $error("accepted request without a move command");

  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(stage_reg) && $stable(fault_latched) && $stable(read_fail_count))
    else $error("state changed without an event");

endmodule

FILE: tb/sv/multi_axis_homing_sequencer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_axis_homing_sequencer_tb
// Self-checking bench for the homing sequencer. Event beats go in on the
// slave stream, and every beat is also run through a local model of the
// stage, fault and pulse-count logic. Each status beat from the master
// stream is compared field by field with the oldest predicted status.
// Directed events come first, then random traffic under several register
// settings, with random stalls on both streams and a long output hold-off.
// ----------------------------------------------------------------------------
module multi_axis_homing_sequencer_tb;
  import mahs_pkg::*;

  localparam int NUM_AXES       = 9;
  localparam int COUNT_BITS     = 24;
  localparam int IN_W           = ((38 + 2 * NUM_AXES + 7) / 8) * 8;
  localparam int OUT_W          = ((13 + 2 * NUM_AXES + 7) / 8) * 8;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 8;

  // op codes the block does not define
  localparam logic [OP_W-1:0] OP_UNUSED_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED_7 = 3'd7;

  // event beat fields, lowest bit last
  typedef struct packed {
    logic                manual_mode;
    logic                overtravel_right;
    logic                overtravel_left;
    logic                all_within_approach;
    logic                move_done;
    logic [NUM_AXES-1:0] step_mask;
    logic [NUM_AXES-1:0] home_sensors;
    logic                io_valid;
    logic [31:0]         time_ms;
  } homing_event_t;

  // status beat fields, lowest bit last
  typedef struct packed {
    evt_t                event_code;
    logic                request_accepted;
    logic                positions_valid;
    fault_kind_t         fault_kind;
    logic [NUM_AXES-1:0] fault_axes;
    logic                fault_active;
    cmd_t                command;
    logic [NUM_AXES-1:0] run_mask;
    stage_t              stage;
  } homing_status_t;

  localparam int STATUS_BITS = $bits(homing_status_t);

  logic                  clk = 1'b0;
  logic                  rst;
  logic [OP_W-1:0]       s_tuser;   // op
  // time_ms, io_valid, home_sensors, step_mask, move_done,
  // all_within_approach, overtravel_left, overtravel_right, manual_mode
  logic [IN_W-1:0]       s_tdata;
  logic                  s_tvalid;
  logic                  s_tready;
  // stage, run_mask, command, fault_active, fault_axes, fault_kind,
  // positions_valid, request_accepted, event_code
  logic [OUT_W-1:0]      m_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_data;

  // register shadows
  logic [MAX_STEPS_W-1:0] lim_steps;
  logic [TIMEOUT_W-1:0]   lim_time;
  logic [RF_W-1:0]        lim_rf;
  logic                   approach_en;
  logic                   overtravel_en;

  // sequencer state as the model sees it
  stage_t                 stage_q;
  logic                   pos_valid_q;
  logic                   fault_q;
  logic [NUM_AXES-1:0]    fault_axes_q;
  fault_kind_t            fault_kind_q;
  logic [RF_W-1:0]        rf_count_q;
  logic [31:0]            casc_t0_q;
  logic                   start_pos_valid_q;
  logic [COUNT_BITS-1:0]  pulse_cnt_q [NUM_AXES];

  // per-event outputs being built
  cmd_t                   p_cmd;
  evt_t                   p_evt;
  logic [NUM_AXES-1:0]    p_run;
  logic                   p_acc;

  homing_status_t         expected_status [$];
  homing_status_t         seen_status;
  homing_status_t         want_status;
  logic [31:0]            now_ms;
  int                     fail_count;
  int                     quiet_cycles;
  bit                     hold_results;
  bit                     sink_gaps;

  multi_axis_homing_sequencer #(
    .NUM_AXES   (NUM_AXES),
    .COUNT_BITS (COUNT_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ------------------------------------------------------------------
  // homing model
  // ------------------------------------------------------------------

  function automatic void clear_model();
    lim_steps         = MAX_STEPS_RST;
    lim_time          = TIMEOUT_RST;
    lim_rf            = RF_LIMIT_RST;
    approach_en       = 1'b1;
    overtravel_en     = 1'b1;
    stage_q           = STAGE_IDLE;
    pos_valid_q       = 1'b0;
    fault_q           = 1'b0;
    fault_axes_q      = '0;
    fault_kind_q      = FK_NONE;
    rf_count_q        = '0;
    casc_t0_q         = '0;
    start_pos_valid_q = 1'b0;
    foreach (pulse_cnt_q[i]) pulse_cnt_q[i] = '0;
  endfunction

  function automatic void start_cascade(logic [31:0] t_ms);
    start_pos_valid_q = pos_valid_q;
    rf_count_q        = '0;
    casc_t0_q         = t_ms;
    foreach (pulse_cnt_q[i]) pulse_cnt_q[i] = '0;
    stage_q           = STAGE_CASCADE;
    p_cmd             = CMD_START;
    p_evt             = EVT_CASCADE_START;
  endfunction

  function automatic void latch_fault(logic [NUM_AXES-1:0] axes, fault_kind_t kind);
    stage_q      = STAGE_IDLE;
    fault_q      = 1'b1;
    pos_valid_q  = 1'b0;
    fault_axes_q = axes;
    fault_kind_q = kind;
    p_run        = '0;
    p_cmd        = (kind == FK_OVERTRAVEL) ? CMD_ESTOP : CMD_STOP;
    p_evt        = (kind == FK_OVERTRAVEL) ? EVT_OT_TRIP : EVT_AXIS_FAULT;
  endfunction

  // service tick while the pulse cascade runs
  function automatic void cascade_tick(homing_event_t ev);
    logic [NUM_AXES-1:0] not_home;
    logic [NUM_AXES-1:0] over;
    logic [31:0]         elapsed;
    // count pulses first, saturating
    for (int i = 0; i < NUM_AXES; i++)
      if (ev.step_mask[i] && pulse_cnt_q[i] != {COUNT_BITS{1'b1}})
        pulse_cnt_q[i] = pulse_cnt_q[i] + 1'b1;
    if (!ev.io_valid) begin
      p_cmd = CMD_STOP;
      if (rf_count_q != RF_COUNT_MAX) rf_count_q = rf_count_q + 1'b1;
      if (rf_count_q == 8'd1) p_evt = EVT_READ_FAIL;
      if (rf_count_q >= lim_rf) latch_fault('1, FK_HOMING);
    end else begin
      rf_count_q = '0;
      not_home   = ~ev.home_sensors;
      over       = '0;
      for (int i = 0; i < NUM_AXES; i++)
        if (not_home[i] && pulse_cnt_q[i] > lim_steps) over[i] = 1'b1;
      elapsed = ev.time_ms - casc_t0_q;
      // over-limit beats timeout beats completion
      if (over != '0) begin
        latch_fault(over, FK_HOMING);
      end else if (elapsed > lim_time) begin
        latch_fault(not_home, FK_HOMING);
      end else if (not_home == '0) begin
        pos_valid_q = 1'b1;
        stage_q     = STAGE_IDLE;
        p_cmd       = CMD_STOP;
        p_evt       = EVT_DONE;
      end else begin
        p_run = not_home;
      end
    end
  endfunction

  function automatic homing_status_t predict_homing(logic [OP_W-1:0] op, homing_event_t ev);
    homing_status_t      st;
    logic [NUM_AXES-1:0] ends;
    p_cmd = CMD_NONE;
    p_evt = EVT_NONE;
    p_run = '0;
    p_acc = 1'b0;
    case (op)
      OP_TICK: begin
        if (stage_q == STAGE_APPROACH) begin
          if (ev.move_done) start_cascade(ev.time_ms);
        end else if (stage_q == STAGE_CASCADE) begin
          cascade_tick(ev);
        end
      end
      OP_HOME: begin
        if (!fault_q && stage_q == STAGE_IDLE) begin
          p_acc = 1'b1;
          if (!pos_valid_q) start_cascade(ev.time_ms);
          else if (!approach_en) p_cmd = CMD_MOVE_ZERO;
          else if (ev.all_within_approach) start_cascade(ev.time_ms);
          else begin
            stage_q = STAGE_APPROACH;
            p_cmd   = CMD_APPROACH;
          end
        end
      end
      OP_ABORT: begin
        if (stage_q == STAGE_CASCADE) begin
          if (!start_pos_valid_q) pos_valid_q = 1'b0;
          p_cmd = CMD_STOP;
        end
        stage_q = STAGE_IDLE;
        p_evt   = EVT_ABORT;
      end
      OP_FAULT_RESET: begin
        if (fault_q) begin
          fault_q      = 1'b0;
          fault_axes_q = '0;
          fault_kind_q = FK_NONE;
          start_cascade(ev.time_ms);
        end
      end
      OP_OVERTRAVEL: begin
        if (overtravel_en && !fault_q && stage_q != STAGE_CASCADE && !ev.manual_mode) begin
          ends = '0;
          if (ev.io_valid) begin
            ends[0]          = ev.overtravel_left;
            ends[NUM_AXES-1] = ev.overtravel_right;
          end
          // nothing readable: name both end axes
          if (ends == '0) begin
            ends[0]          = 1'b1;
            ends[NUM_AXES-1] = 1'b1;
          end
          latch_fault(ends, FK_OVERTRAVEL);
        end
      end
      OP_POWER_UP: begin
        if (!ev.io_valid) latch_fault('1, FK_HOMING);
        else if (ev.manual_mode) ;
        else if (ev.home_sensors == '1) pos_valid_q = 1'b1;
        else start_cascade(ev.time_ms);
      end
      default: ;
    endcase
    st.stage            = stage_q;
    st.run_mask         = p_run;
    st.command          = p_cmd;
    st.fault_active     = fault_q;
    st.fault_axes       = fault_axes_q;
    st.fault_kind       = fault_kind_q;
    st.positions_valid  = pos_valid_q;
    st.request_accepted = p_acc;
    st.event_code       = p_evt;
    return st;
  endfunction

  // ------------------------------------------------------------------
  // stimulus helpers
  // ------------------------------------------------------------------

  function automatic homing_event_t quiet_event(logic [31:0] t_ms);
    homing_event_t ev;
    ev          = '0;
    ev.time_ms  = t_ms;
    ev.io_valid = 1'b1;
    return ev;
  endfunction

  // time mostly creeps forward, with rare jumps anywhere
  function automatic homing_event_t random_event();
    homing_event_t ev;
    if ($urandom_range(0, 49) == 0) now_ms = $urandom;
    else now_ms = now_ms + $urandom_range(0, 60);
    ev                     = '0;
    ev.time_ms             = now_ms;
    ev.io_valid            = ($urandom_range(0, 9) != 0);
    ev.home_sensors        = ($urandom_range(0, 3) == 0) ? '1 : NUM_AXES'($urandom);
    ev.step_mask           = NUM_AXES'($urandom);
    ev.move_done           = 1'($urandom_range(0, 1));
    ev.all_within_approach = 1'($urandom_range(0, 1));
    ev.overtravel_left     = 1'($urandom_range(0, 1));
    ev.overtravel_right    = 1'($urandom_range(0, 1));
    ev.manual_mode         = ($urandom_range(0, 7) == 0);
    return ev;
  endfunction

  function automatic logic [OP_W-1:0] random_op();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return OP_TICK;
    if (r < 67) return OP_HOME;
    if (r < 72) return OP_ABORT;
    if (r < 80) return OP_FAULT_RESET;
    if (r < 86) return OP_OVERTRAVEL;
    if (r < 97) return OP_POWER_UP;
    return $urandom_range(0, 1) ? OP_UNUSED_6 : OP_UNUSED_7;
  endfunction

  // offer one event beat and log its predicted status once taken
  task automatic send_event(input logic [OP_W-1:0] op, input homing_event_t ev);
    s_tuser  <= op;
    s_tdata  <= IN_W'(ev);
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_status.push_back(predict_homing(op, ev));
  endtask

  task automatic drain_results();
    if (s_tvalid) s_tvalid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
  endtask

  // all five registers, written back to back while the block is empty
  task automatic apply_settings(input logic [MAX_STEPS_W-1:0] steps,
                                input logic [TIMEOUT_W-1:0] tmo,
                                input logic [RF_W-1:0] rf,
                                input logic appr, input logic ot);
    drain_results();
    cfg_we   <= 1'b1;
    cfg_addr <= CFG_MAX_STEPS;
    cfg_data <= CFG_DATA_W'(steps);
    @(posedge clk);
    cfg_addr <= CFG_TIMEOUT_MS;
    cfg_data <= CFG_DATA_W'(tmo);
    @(posedge clk);
    cfg_addr <= CFG_READ_FAIL_LIMIT;
    cfg_data <= CFG_DATA_W'(rf);
    @(posedge clk);
    cfg_addr <= CFG_APPROACH_EN;
    cfg_data <= CFG_DATA_W'(appr);
    @(posedge clk);
    cfg_addr <= CFG_OVERTRAVEL_EN;
    cfg_data <= CFG_DATA_W'(ot);
    @(posedge clk);
    cfg_we        <= 1'b0;
    lim_steps     = steps;
    lim_time      = tmo;
    lim_rf        = rf;
    approach_en   = appr;
    overtravel_en = ot;
  endtask

  task automatic apply_random_settings();
    apply_settings(MAX_STEPS_W'($urandom_range(0, 40)), TIMEOUT_W'($urandom_range(0, 3000)),
                   RF_W'($urandom_range(1, 6)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
  endtask

  task automatic run_random(input int count, input bit gaps);
    for (int n = 0; n < count; n++) begin
      if (gaps && $urandom_range(0, 4) == 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      send_event(random_op(), random_event());
    end
  endtask

  // ------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------

  // one pass through every op and special case at reset settings
  task automatic test_directed_events();
    homing_event_t ev;
    ev = quiet_event(32'h0);
    send_event(OP_UNUSED_6, ev);
    send_event(OP_UNUSED_7, ev);
    send_event(OP_ABORT, ev);                  // abort while idle
    send_event(OP_HOME, ev);                   // positions invalid: straight to cascade
    ev.step_mask = '1;
    send_event(OP_TICK, ev);                   // all axes run
    ev.io_valid  = 1'b0;
    ev.step_mask = '0;
    repeat (5) send_event(OP_TICK, ev);        // read failures up to the limit
    ev = quiet_event(32'hFFFF_FFFF);
    ev.overtravel_left = 1'b1;
    send_event(OP_OVERTRAVEL, ev);             // ignored under a latched fault
    send_event(OP_HOME, ev);                   // refused under a latched fault
    send_event(OP_FAULT_RESET, quiet_event(32'hFFFF_FFF0));
    ev = quiet_event(32'h10);
    ev.home_sensors = '1;
    ev.step_mask    = '1;
    send_event(OP_TICK, ev);                   // all home across time wrap
    ev = quiet_event(32'h20);
    send_event(OP_HOME, ev);                   // approach move
    send_event(OP_TICK, ev);                   // move not done yet
    ev.move_done = 1'b1;
    send_event(OP_TICK, ev);                   // approach done, cascade
    send_event(OP_ABORT, ev);                  // positions kept
    ev = quiet_event(32'd100);
    ev.all_within_approach = 1'b1;
    send_event(OP_HOME, ev);                   // already close, cascade
    ev = quiet_event(32'd30101);
    ev.home_sensors = 9'h0F0;
    send_event(OP_TICK, ev);                   // timeout names axes not home
    ev = quiet_event(32'd30200);
    send_event(OP_FAULT_RESET, ev);
    send_event(OP_OVERTRAVEL, ev);             // ignored during cascade
    send_event(OP_ABORT, ev);                  // positions lost
    ev.overtravel_right = 1'b1;
    ev.manual_mode      = 1'b1;
    send_event(OP_OVERTRAVEL, ev);             // ignored in manual mode
    ev.manual_mode = 1'b0;
    send_event(OP_OVERTRAVEL, ev);             // right end only
    send_event(OP_POWER_UP, quiet_event(32'd0));
    ev = quiet_event(32'd0);
    ev.manual_mode = 1'b1;
    send_event(OP_POWER_UP, ev);               // manual: nothing
    ev = quiet_event(32'd5);
    ev.io_valid = 1'b0;
    ev.overtravel_left = 1'b1;
    send_event(OP_POWER_UP, ev);               // unreadable: fault on all axes
  endtask

  // register extremes and the move-to-zero path
  task automatic test_config_phases();
    homing_event_t ev;
    apply_settings('0, '0, 8'd1, 1'b0, 1'b0);
    ev = quiet_event(now_ms);
    ev.home_sensors = '1;
    send_event(OP_FAULT_RESET, ev);
    send_event(OP_ABORT, ev);
    send_event(OP_POWER_UP, ev);               // all home: positions valid
    send_event(OP_HOME, ev);                   // no approach: move to zero
    run_random(150, 1'b1);
    apply_settings('1, '1, 8'd255, 1'b1, 1'b1);
    run_random(150, 1'b1);
    apply_settings(MAX_STEPS_RST, TIMEOUT_RST, RF_LIMIT_RST, 1'b1, 1'b1);
    ev = quiet_event(now_ms);
    ev.io_valid = 1'b0;
    send_event(OP_OVERTRAVEL, ev);             // both ends named
    run_random(100, 1'b1);
  endtask

  // long output stall fills the block, then the sender waits for all results
  task automatic test_backpressure();
    apply_random_settings();
    hold_results = 1'b1;
    run_random(40, 1'b0);
    drain_results();
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 6; phase++) begin
      apply_random_settings();
      run_random(130, 1'b1);
    end
  endtask

  // no idling on either side
  task automatic test_full_rate();
    apply_random_settings();
    sink_gaps = 1'b0;
    run_random(150, 1'b0);
  endtask

  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tuser  <= '0;
    s_tdata  <= '0;
    cfg_we   <= 1'b0;
    cfg_addr <= '0;
    cfg_data <= '0;
    now_ms       = '0;
    fail_count   = 0;
    hold_results = 1'b0;
    sink_gaps    = 1'b1;
    clear_model();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed_events();
    test_config_phases();
    test_backpressure();
    test_random_traffic();
    test_full_rate();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  // ------------------------------------------------------------------
  // result side
  // ------------------------------------------------------------------

  // output ready: random stalls, plus one long hold-off on request
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_results) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results = 1'b0;
      end else if (sink_gaps && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  function automatic int check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // compare each status beat with the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen_status = m_tdata[STATUS_BITS-1:0];
      if (expected_status.size() == 0) begin
        $error("status beat with no event outstanding");
        fail_count++;
      end else begin
        want_status = expected_status.pop_front();
        fail_count += check_field("stage", want_status.stage, seen_status.stage);
        fail_count += check_field("run_mask", want_status.run_mask, seen_status.run_mask);
        fail_count += check_field("command", want_status.command, seen_status.command);
        fail_count += check_field("fault_active", want_status.fault_active,
                                  seen_status.fault_active);
        fail_count += check_field("fault_axes", want_status.fault_axes,
                                  seen_status.fault_axes);
        fail_count += check_field("fault_kind", want_status.fault_kind,
                                  seen_status.fault_kind);
        fail_count += check_field("positions_valid", want_status.positions_valid,
                                  seen_status.positions_valid);
        fail_count += check_field("request_accepted", want_status.request_accepted,
                                  seen_status.request_accepted);
        fail_count += check_field("event_code", want_status.event_code,
                                  seen_status.event_code);
      end
    end
  end

  // watchdog on cycles with no beat on either stream
  always @(posedge clk) begin
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

endmodule
